// ===== rtl/core/tns_pkg.sv =====
// Package for the tempo note sequencer: table geometry, field widths,
// request opcodes, register indexes and the note entry type. No dependencies.
`default_nettype none
package tns_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int LEN_W       = 9;
   localparam int TEMPO_W     = 10;
   localparam int FREQ_W      = 16;
   localparam int NLEN_W      = 16;
   localparam int DUR_W       = 24;
   localparam int PROD_W      = 32;
   localparam int OP_W        = 2;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 10;

   localparam int MS_PER_MIN  = 60000;
   localparam int TEMPO_RESET = 120;

   localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
   localparam logic [OP_W-1:0] OP_START = 2'd2;
   localparam logic [OP_W-1:0] OP_STOP  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_TEMPO    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LOOP     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SONG_LEN = 2'd2;

   typedef struct packed {
      logic [FREQ_W-1:0] freq;
      logic [NLEN_W-1:0] len;
   } note_entry_type;

endpackage
`default_nettype wire

// ===== rtl/core/tns_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module tns_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/tempo_note_sequencer_core.sv =====
// Top level of the tempo note sequencer: control sequencer, duration divider
// and output register. Depends on tns_pkg and tns_ram.
//
// Use: requests arrive on req_* (valid/stall); each request gives exactly one
// response on rsp_* (valid/stall). Opcodes: tick (one millisecond), load
// note, start, stop. Registers tempo, loop enable and song length are written
// through csr_* (valid/ready, ready always high); the user must write them
// only while the block is idle, which the block itself does not enforce.
// One request is worked on at a time; req_stall is high while it is.
// Load, stop, a rejected start and a tick that enters no new note go straight
// to the response state. A start or a tick that enters a note reads the note
// table, multiplies the length by 60000, keeps the top 24 bits of the product
// and runs a restoring divider by the tempo, one quotient bit a cycle; the
// response follows, and req_stall falls as it enters the output register.
// The response sits in an output register; a stalled response holds, and the
// block takes and works on the next request meanwhile, waiting only to hand
// over its own response.
// Reset (synchronous, active high) stops playback, clears the play index and
// countdown and sets tempo 120, loop off, song length 0. The note table is
// not cleared; entries are undefined until loaded.
`default_nettype none
module tempo_note_sequencer_core (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [tns_pkg::OP_W-1:0]         req_opcode,
   input  wire logic [7:0]                       req_note_index,
   input  wire logic [15:0]                      req_note_freq_hz,
   input  wire logic [15:0]                      req_note_length_q,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic                                  rsp_tone_update,
   output logic      [15:0]                      rsp_tone_hz,
   output logic                                  rsp_is_playing,
   output logic      [7:0]                       rsp_current_note,
   output logic                                  rsp_song_ended,
   output logic                                  rsp_start_rejected,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [tns_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [tns_pkg::CSR_DATA_W-1:0]   csr_data
);
   import tns_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_READ = 3'd1;
   localparam logic [2:0] S_DIV  = 3'd2;
   localparam logic [2:0] S_RESP = 3'd3;

   localparam int CNT_W = $clog2(DUR_W);

   logic [2:0]         state_ff, state_in;
   logic [IDX_W-1:0]   play_index_ff, play_index_in;
   logic [DUR_W-1:0]   remaining_ff, remaining_in;
   logic               running_ff, running_in;
   logic [FREQ_W-1:0]  tone_ff, tone_in;
   logic               ended_ff, ended_in;
   logic               rejected_ff, rejected_in;
   logic [DUR_W-1:0]   div_quot_ff, div_quot_in;
   logic [TEMPO_W-1:0] div_rem_ff, div_rem_in;
   logic [CNT_W-1:0]   div_cnt_ff, div_cnt_in;
   logic [TEMPO_W-1:0] tempo_ff;
   logic               loop_ff;
   logic [LEN_W-1:0]   song_len_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_update_ff;
   logic [FREQ_W-1:0]  rsp_tone_ff;
   logic               rsp_playing_ff;
   logic [IDX_W-1:0]   rsp_note_ff;
   logic               rsp_ended_ff;
   logic               rsp_rejected_ff;

   logic               req_accept;
   logic               rsp_load;
   logic [LEN_W-1:0]   eff_len;
   logic [LEN_W-1:0]   next_index;
   logic [DUR_W-1:0]   rem_dec;
   logic [TEMPO_W-1:0] divisor;
   logic [TEMPO_W:0]   rem_shift;
   logic               quot_bit;
   logic [PROD_W-1:0]  product;

   logic               ram_wr_en;
   logic               ram_rd_en;
   logic [IDX_W-1:0]   ram_rd_addr;
   note_entry_type     ram_wr_data;
   note_entry_type     ram_rd_data;

   tns_ram #(
      .WIDTH($bits(note_entry_type)),
      .DEPTH(TABLE_DEPTH)
   ) u_note_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (req_note_index),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;
   assign rsp_load   = (state_ff == S_RESP) && (!rsp_valid_ff || !rsp_stall);

   assign ram_wr_data.freq = req_note_freq_hz;
   assign ram_wr_data.len  = req_note_length_q;
   assign ram_wr_en = req_accept && (req_opcode == OP_LOAD)
                      && ({1'b0, req_note_index} < LEN_W'(TABLE_DEPTH));

   assign eff_len    = (song_len_ff > LEN_W'(TABLE_DEPTH)) ? LEN_W'(TABLE_DEPTH) : song_len_ff;
   assign next_index = LEN_W'(play_index_ff) + LEN_W'(1);
   assign rem_dec    = (remaining_ff != '0) ? remaining_ff - DUR_W'(1) : '0;
   assign divisor    = (tempo_ff == '0) ? TEMPO_W'(1) : tempo_ff;
   assign rem_shift  = {div_rem_ff, div_quot_ff[DUR_W-1]};
   assign quot_bit   = (rem_shift >= {1'b0, divisor});
   assign product    = PROD_W'(MS_PER_MIN) * PROD_W'(ram_rd_data.len);

   always_comb begin
      state_in      = state_ff;
      play_index_in = play_index_ff;
      remaining_in  = remaining_ff;
      running_in    = running_ff;
      tone_in       = tone_ff;
      ended_in      = ended_ff;
      rejected_in   = rejected_ff;
      div_quot_in   = div_quot_ff;
      div_rem_in    = div_rem_ff;
      div_cnt_in    = div_cnt_ff;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = req_note_index;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               tone_in     = '0;
               ended_in    = 1'b0;
               rejected_in = 1'b0;
               state_in    = S_RESP;
               case (req_opcode)
                  OP_LOAD: begin
                  end
                  OP_STOP: begin
                     running_in = 1'b0;
                  end
                  OP_START: begin
                     if (eff_len == '0 || {1'b0, req_note_index} >= eff_len) begin
                        rejected_in = 1'b1;
                     end else begin
                        running_in    = 1'b1;
                        play_index_in = req_note_index;
                        ram_rd_en     = 1'b1;
                        ram_rd_addr   = req_note_index;
                        state_in      = S_READ;
                     end
                  end
                  default: begin
                     if (running_ff) begin
                        remaining_in = rem_dec;
                        if (rem_dec == '0) begin
                           if (next_index >= eff_len) begin
                              if (loop_ff && eff_len != '0) begin
                                 play_index_in = '0;
                                 ram_rd_en     = 1'b1;
                                 ram_rd_addr   = '0;
                                 state_in      = S_READ;
                              end else begin
                                 running_in = 1'b0;
                                 ended_in   = 1'b1;
                              end
                           end else begin
                              play_index_in = IDX_W'(next_index);
                              ram_rd_en     = 1'b1;
                              ram_rd_addr   = IDX_W'(next_index);
                              state_in      = S_READ;
                           end
                        end
                     end
                  end
               endcase
            end
         end
         S_READ: begin
            tone_in     = ram_rd_data.freq;
            div_quot_in = product[PROD_W-1 -: DUR_W];
            div_rem_in  = '0;
            div_cnt_in  = '0;
            state_in    = S_DIV;
         end
         S_DIV: begin
            div_rem_in  = quot_bit ? TEMPO_W'(rem_shift - {1'b0, divisor})
                                   : TEMPO_W'(rem_shift);
            div_quot_in = {div_quot_ff[DUR_W-2:0], quot_bit};
            div_cnt_in  = div_cnt_ff + CNT_W'(1);
            if (div_cnt_ff == CNT_W'(DUR_W - 1)) begin
               remaining_in = {div_quot_ff[DUR_W-2:0], quot_bit};
               state_in     = S_RESP;
            end
         end
         S_RESP: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         play_index_ff <= '0;
         remaining_ff  <= '0;
         running_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         tempo_ff      <= TEMPO_W'(TEMPO_RESET);
         loop_ff       <= 1'b0;
         song_len_ff   <= '0;
      end else begin
         state_ff      <= state_in;
         play_index_ff <= play_index_in;
         remaining_ff  <= remaining_in;
         running_ff    <= running_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_TEMPO:    tempo_ff    <= csr_data;
               REG_LOOP:     loop_ff     <= csr_data[0];
               REG_SONG_LEN: song_len_ff <= csr_data[LEN_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      tone_ff     <= tone_in;
      ended_ff    <= ended_in;
      rejected_ff <= rejected_in;
      div_quot_ff <= div_quot_in;
      div_rem_ff  <= div_rem_in;
      div_cnt_ff  <= div_cnt_in;
      if (rsp_load) begin
         rsp_update_ff   <= (tone_ff != '0);
         rsp_tone_ff     <= tone_ff;
         rsp_playing_ff  <= running_ff;
         rsp_note_ff     <= play_index_ff;
         rsp_ended_ff    <= ended_ff;
         rsp_rejected_ff <= rejected_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_tone_update    = rsp_update_ff;
   assign rsp_tone_hz        = rsp_tone_ff;
   assign rsp_is_playing     = rsp_playing_ff;
   assign rsp_current_note   = rsp_note_ff;
   assign rsp_song_ended     = rsp_ended_ff;
   assign rsp_start_rejected = rsp_rejected_ff;

endmodule
`default_nettype wire

// ===== tb/tns_play_checker.sv =====
// Checker for the tempo note sequencer: watches the request, response and
// register channels, predicts each response and compares it field by field.
// Depends on tns_pkg.
module tns_play_checker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   input  wire logic                           req_stall,
   input  wire logic [tns_pkg::OP_W-1:0]       req_opcode,
   input  wire logic [7:0]                     req_note_index,
   input  wire logic [15:0]                    req_note_freq_hz,
   input  wire logic [15:0]                    req_note_length_q,
   input  wire logic                           rsp_valid,
   input  wire logic                           rsp_stall,
   input  wire logic                           rsp_tone_update,
   input  wire logic [15:0]                    rsp_tone_hz,
   input  wire logic                           rsp_is_playing,
   input  wire logic [7:0]                     rsp_current_note,
   input  wire logic                           rsp_song_ended,
   input  wire logic                           rsp_start_rejected,
   input  wire logic                           csr_valid,
   input  wire logic                           csr_ready,
   input  wire logic [tns_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [tns_pkg::CSR_DATA_W-1:0] csr_data,
   output int                                  outstanding,
   output int                                  fail_count
);
   import tns_pkg::*;

   typedef struct packed {
      logic        tone_update;
      logic [15:0] tone_hz;
      logic        is_playing;
      logic [7:0]  current_note;
      logic        song_ended;
      logic        start_rejected;
   } note_result_type;

   logic [FREQ_W-1:0]  freq_mem [TABLE_DEPTH];
   logic [NLEN_W-1:0]  len_mem  [TABLE_DEPTH];
   logic [7:0]         play_ptr;
   logic [DUR_W-1:0]   ms_left;
   logic               playing;
   logic [TEMPO_W-1:0] tempo;
   logic               looping;
   logic [LEN_W-1:0]   song_len;

   note_result_type due_results [$];
   int fails = 0;

   assign fail_count = fails;

   function automatic logic [DUR_W-1:0] note_ms(logic [NLEN_W-1:0] len_q);
      longint unsigned bpm;
      longint unsigned num;
      bpm = (tempo == 0) ? 1 : longint'(tempo);
      num = longint'(MS_PER_MIN) * longint'(len_q);
      return DUR_W'(num / (bpm * 256));
   endfunction

   function automatic logic [FREQ_W-1:0] enter_note();
      ms_left = note_ms(len_mem[play_ptr]);
      return freq_mem[play_ptr];
   endfunction

   function automatic note_result_type advance_player(logic [OP_W-1:0] op, logic [7:0] idx,
                                                      logic [15:0] hz, logic [15:0] len_q);
      note_result_type r;
      logic [FREQ_W-1:0] tone;
      logic [LEN_W:0] span;
      logic [LEN_W:0] nxt;
      logic ended;
      logic rejected;
      tone = '0;
      ended = 1'b0;
      rejected = 1'b0;
      span = (song_len > TABLE_DEPTH) ? (LEN_W+1)'(TABLE_DEPTH) : (LEN_W+1)'(song_len);
      case (op)
         OP_LOAD: begin
            freq_mem[idx] = hz;
            len_mem[idx] = len_q;
         end
         OP_START: begin
            if (span == 0 || idx >= span) begin
               rejected = 1'b1;
            end else begin
               playing = 1'b1;
               play_ptr = idx;
               tone = enter_note();
            end
         end
         OP_STOP: playing = 1'b0;
         OP_TICK: begin
            if (playing) begin
               if (ms_left != 0) ms_left = ms_left - 1'b1;
               if (ms_left == 0) begin
                  nxt = (LEN_W+1)'(play_ptr) + 1'b1;
                  if (nxt >= span) begin
                     if (looping && span != 0) begin
                        nxt = '0;
                     end else begin
                        playing = 1'b0;
                        ended = 1'b1;
                     end
                  end
                  if (playing) begin
                     play_ptr = nxt[7:0];
                     tone = enter_note();
                  end
               end
            end
         end
         default: ;
      endcase
      r.tone_update = (tone != 0);
      r.tone_hz = tone;
      r.is_playing = playing;
      r.current_note = play_ptr;
      r.song_ended = ended;
      r.start_rejected = rejected;
      return r;
   endfunction

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fails++;
      end
   endtask

   always @(posedge clock) begin : watch
      note_result_type want;
      if (reset) begin
         for (int k = 0; k < TABLE_DEPTH; k++) begin
            freq_mem[k] = '0;
            len_mem[k] = '0;
         end
         play_ptr = '0;
         ms_left = '0;
         playing = 1'b0;
         tempo = TEMPO_W'(TEMPO_RESET);
         looping = 1'b0;
         song_len = '0;
         due_results.delete();
         outstanding <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_TEMPO:    tempo = csr_data[TEMPO_W-1:0];
               REG_LOOP:     looping = csr_data[0];
               REG_SONG_LEN: song_len = csr_data[LEN_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (due_results.size() == 0) begin
               $error("response with no request outstanding");
               fails++;
            end else begin
               want = due_results.pop_front();
               check_field("tone_update", want.tone_update, rsp_tone_update);
               check_field("tone_hz", want.tone_hz, rsp_tone_hz);
               check_field("is_playing", want.is_playing, rsp_is_playing);
               check_field("current_note", want.current_note, rsp_current_note);
               check_field("song_ended", want.song_ended, rsp_song_ended);
               check_field("start_rejected", want.start_rejected, rsp_start_rejected);
            end
         end
         if (req_valid && !req_stall)
            due_results.push_back(advance_player(req_opcode, req_note_index,
                                                 req_note_freq_hz, req_note_length_q));
         outstanding <= due_results.size();
      end
   end

endmodule

// ===== tb/testbench.sv =====
// Top of the tempo note sequencer testbench: clock, reset, request and
// register stimulus, response back-pressure and the verdict.
// Depends on tns_pkg, tempo_note_sequencer_core and tns_play_checker.
module testbench;
   import tns_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int SETTLE      = 4;
   localparam int PHASES      = 9;
   localparam int PHASE_REQS  = 16;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [OP_W-1:0]       req_opcode = OP_TICK;
   logic [7:0]            req_note_index = '0;
   logic [15:0]           req_note_freq_hz = '0;
   logic [15:0]           req_note_length_q = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_tone_update;
   logic [15:0]           rsp_tone_hz;
   logic                  rsp_is_playing;
   logic [7:0]            rsp_current_note;
   logic                  rsp_song_ended;
   logic                  rsp_start_rejected;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = REG_TEMPO;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   int outstanding;
   int fail_count;
   int cycles = 0;
   int stall_left = 0;
   bit calm = 1'b0;
   bit loaded [TABLE_DEPTH];
   int span_now = 0;

   // -1 random tempo / small span, -2 span of the whole loaded prefix
   int phase_tempo [PHASES] = '{120, 1000, 0, 1023, 500, 1, -1, -1, 300};
   int phase_loop  [PHASES] = '{0, 1, 1, 0, 1, 0, 1, -1, 1};
   int phase_span  [PHASES] = '{-1, -1, -1, -2, 256, 511, -1, 0, -1};

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   tempo_note_sequencer_core i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_opcode         (req_opcode),
      .req_note_index     (req_note_index),
      .req_note_freq_hz   (req_note_freq_hz),
      .req_note_length_q  (req_note_length_q),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_tone_update    (rsp_tone_update),
      .rsp_tone_hz        (rsp_tone_hz),
      .rsp_is_playing     (rsp_is_playing),
      .rsp_current_note   (rsp_current_note),
      .rsp_song_ended     (rsp_song_ended),
      .rsp_start_rejected (rsp_start_rejected),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   tns_play_checker i_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_opcode         (req_opcode),
      .req_note_index     (req_note_index),
      .req_note_freq_hz   (req_note_freq_hz),
      .req_note_length_q  (req_note_length_q),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_tone_update    (rsp_tone_update),
      .rsp_tone_hz        (rsp_tone_hz),
      .rsp_is_playing     (rsp_is_playing),
      .rsp_current_note   (rsp_current_note),
      .rsp_song_ended     (rsp_song_ended),
      .rsp_start_rejected (rsp_start_rejected),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .outstanding        (outstanding),
      .fail_count         (fail_count)
   );

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 4);
      return $urandom_range(12, 60);
   endfunction

   function automatic int loaded_prefix();
      int k;
      k = 0;
      while (k < TABLE_DEPTH && loaded[k]) k++;
      return k;
   endfunction

   function automatic logic [15:0] random_freq();
      if ($urandom_range(0, 5) == 0) return '0;
      return 16'($urandom);
   endfunction

   function automatic logic [15:0] random_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return 16'($urandom_range(0, 12));
      if (r < 92) return 16'($urandom_range(0, 255));
      return 16'($urandom);
   endfunction

   function automatic int pick_span(int rule);
      int p;
      p = loaded_prefix();
      if (rule >= 0) return rule;
      if (rule == -2 || p == 0 || $urandom_range(0, 9) == 0) return p;
      return $urandom_range(1, p < 8 ? p : 8);
   endfunction

   // back-pressure on responses: stretches of stall between open windows
   always @(posedge clock) begin : stall_gen
      int n;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else begin
         n = idle_len();
         rsp_stall <= (n != 0);
         stall_left <= (n != 0) ? n - 1 : $urandom_range(0, 6);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic send(logic [OP_W-1:0] op, logic [7:0] idx, logic [15:0] hz,
                       logic [15:0] len_q);
      req_valid <= 1'b1;
      req_opcode <= op;
      req_note_index <= idx;
      req_note_freq_hz <= hz;
      req_note_length_q <= len_q;
      do @(posedge clock); while (req_stall);
      if (op == OP_LOAD) loaded[idx] = 1'b1;
   endtask

   task automatic pause(int n);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= CSR_DATA_W'(value);
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic set_regs(int tempo, int loop_on, int span);
      drain();
      write_reg(REG_TEMPO, tempo);
      write_reg(REG_LOOP, loop_on);
      write_reg(REG_SONG_LEN, span);
      csr_valid <= 1'b0;
      span_now = (span > TABLE_DEPTH) ? TABLE_DEPTH : span;
      @(posedge clock);
   endtask

   task automatic tick();
      pause(idle_len());
      send(OP_TICK, 8'($urandom), 16'($urandom), 16'($urandom));
   endtask

   task automatic req_start(logic [7:0] idx);
      pause(idle_len());
      send(OP_START, idx, 16'($urandom), 16'($urandom));
   endtask

   task automatic req_stop();
      pause(idle_len());
      send(OP_STOP, 8'($urandom), 16'($urandom), 16'($urandom));
   endtask

   task automatic req_load(logic [7:0] idx, logic [15:0] hz, logic [15:0] len_q);
      pause(idle_len());
      send(OP_LOAD, idx, hz, len_q);
   endtask

   task automatic random_request();
      int pick;
      int p;
      logic [7:0] idx;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         tick();
      end else if (pick < 72) begin
         p = loaded_prefix();
         idx = (p < TABLE_DEPTH && $urandom_range(0, 1) == 1) ? 8'(p) : 8'($urandom);
         req_load(idx, random_freq(), random_length());
      end else if (pick < 90) begin
         if (span_now > 0 && $urandom_range(0, 99) < 85)
            idx = 8'($urandom_range(0, span_now - 1));
         else
            idx = 8'($urandom);
         req_start(idx);
      end else begin
         req_stop();
      end
   endtask

   initial begin
      int ph;
      int tempo;
      int loop_on;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty table, idle block
      set_regs(120, 0, 0);
      req_start(8'd0);
      tick();
      req_stop();
      req_load(8'd0, 16'hFFFF, 16'h0000);
      req_load(8'd1, 16'h0000, 16'h0001);
      req_load(8'd2, 16'd440, 16'h0100);
      req_load(8'd3, 16'h0001, 16'hFFFF);
      req_load(8'd255, 16'h5A5A, 16'h0080);

      set_regs(1000, 1, 4);
      req_start(8'd4);
      req_start(8'd255);
      req_start(8'd0);
      tick();
      tick();
      req_stop();
      req_start(8'd3);
      tick();
      tick();
      req_stop();
      req_start(8'd0);
      // song length set to 0 under a playing note, looping on
      set_regs(1000, 1, 0);
      tick();

      for (ph = 0; ph < PHASES; ph++) begin
         if (ph == 4) begin
            for (int k = 0; k < TABLE_DEPTH; k++)
               if (!loaded[k]) req_load(8'(k), random_freq(), 16'($urandom_range(0, 12)));
         end
         calm = (ph == 6);
         tempo = (phase_tempo[ph] < 0) ? $urandom_range(1, 1023) : phase_tempo[ph];
         loop_on = (phase_loop[ph] < 0) ? $urandom_range(0, 1) : phase_loop[ph];
         set_regs(tempo, loop_on, pick_span(phase_span[ph]));
         repeat (PHASE_REQS) begin
            if ($urandom_range(0, 29) == 0) drain();
            random_request();
         end
      end
      calm = 1'b0;

      drain();
      repeat (8 * SETTLE) @(posedge clock);
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
